FILE: rtl/life_grid_generation_step_macros.svh
// assertion macros for the life grid generation step block
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef LIFE_GRID_GENERATION_STEP_MACROS_SVH
`define LIFE_GRID_GENERATION_STEP_MACROS_SVH

// same-cycle implication
`define LGS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lgs_pkg.sv
// shared types, constants and row functions for the life grid block
// no dependencies
package lgs_pkg;

  localparam int COLS         = 64;
  localparam int IDX_W        = 6;
  localparam int SIZE_W       = 7;
  localparam int MAX_GRID_DEF = 64;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ADVANCE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ADV
  } state_e;

  // columns below the active size
  function automatic logic [COLS-1:0] col_mask(input logic [SIZE_W-1:0] n);
    logic [COLS-1:0] m;
    m = '0;
    for (int c = 0; c < COLS; c++) begin
      m[c] = (SIZE_W'(c) < n);
    end
    return m;
  endfunction

  // interior columns: not the first and not the last active column
  function automatic logic [COLS-1:0] inner_mask(input logic [SIZE_W-1:0] n);
    logic [COLS-1:0] m;
    m = '0;
    for (int c = 1; c < COLS; c++) begin
      m[c] = ((SIZE_W'(c) + SIZE_W'(1)) < n);
    end
    return m;
  endfunction

  // b3/s23 rule for a whole row from the rows above, at and below
  function automatic logic [COLS-1:0] life_rule(input logic [COLS-1:0] up,
                                                input logic [COLS-1:0] md,
                                                input logic [COLS-1:0] dn);
    logic [COLS-1:0] nxt;
    logic [3:0]      cnt;
    int              cl;
    int              cr;
    nxt = '0;
    for (int c = 0; c < COLS; c++) begin
      cl  = (c + COLS - 1) % COLS;
      cr  = (c + 1) % COLS;
      cnt = 4'(up[cl]) + 4'(up[c]) + 4'(up[cr]) + 4'(md[cl]) + 4'(md[cr])
          + 4'(dn[cl]) + 4'(dn[c]) + 4'(dn[cr]);
      nxt[c] = (cnt == 4'd3) || (md[c] && (cnt == 4'd2));
    end
    return nxt;
  endfunction

endpackage

FILE: rtl/lgs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module lgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/life_grid_generation_step.sv
// game of life grid (b3/s23, dead border) with row write, row read and advance
// depends on lgs_pkg, lgs_ram and life_grid_generation_step_macros.svh
//
// A command is taken when start is high and busy is low. Write and the unused
// command give their result on the cycle after acceptance and never raise busy;
// read keeps busy high while in its read state, and its result follows in the
// first cycle with busy low. Advance sweeps the grid through the single read
// port of the row memory, one row per cycle with a three-row window, and keeps
// busy high until it has written the last row; its result likewise follows in
// the first cycle with busy low, and the next command can be taken in that same
// cycle. Each result shows on done_o for exactly one cycle and must be taken
// then: the receiver cannot stall. Row contents are cleared at reset by per-row
// valid flags, so no clearing pass is needed.
`include "life_grid_generation_step_macros.svh"

module life_grid_generation_step
  import lgs_pkg::*;
#(
  parameter int MAX_GRID = MAX_GRID_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  input  logic [1:0]        command_i,
  input  logic [IDX_W-1:0]  row_index_i,
  input  logic [COLS-1:0]   row_bits_i,
  output logic              done_o,
  output logic [COLS-1:0]   read_bits_o,
  output logic              index_valid_o
);

  localparam int AW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;

  state_e            state_q, state_d;
  logic [SIZE_W-1:0] grid_size_q;
  logic [SIZE_W-1:0] n_act;
  logic [SIZE_W-1:0] cnt_q, cnt_d;
  logic [SIZE_W-1:0] wrow;
  logic              idx_vld_q, idx_vld_d;
  logic              idx_ok;
  logic              accept;
  logic [MAX_GRID-1:0] row_vld_q;
  logic              rd_vld_q;
  logic [COLS-1:0]   up_q, up_d, mid_q, mid_d;
  logic [COLS-1:0]   ram_rdata, rdata_m;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [COLS-1:0]   ram_wdata;
  logic              done_q, done_d;
  logic [COLS-1:0]   read_bits_q, read_bits_d;
  logic              index_valid_q, index_valid_d;

  assign n_act   = (grid_size_q > SIZE_W'(MAX_GRID)) ? SIZE_W'(MAX_GRID) : grid_size_q;
  assign idx_ok  = ({1'b0, row_index_i} < n_act);
  assign accept  = start && !busy;
  assign busy    = (state_q != ST_IDLE);
  assign rdata_m = ram_rdata & {COLS{rd_vld_q}};
  assign wrow    = cnt_q - SIZE_W'(2);

  lgs_ram #(
    .WIDTH(COLS),
    .DEPTH(MAX_GRID)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      grid_size_q   <= SIZE_W'(MAX_GRID_DEF);
      cnt_q         <= '0;
      idx_vld_q     <= 1'b0;
      row_vld_q     <= '0;
      rd_vld_q      <= 1'b0;
      done_q        <= 1'b0;
      read_bits_q   <= '0;
      index_valid_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      idx_vld_q     <= idx_vld_d;
      rd_vld_q      <= row_vld_q[ram_raddr];
      done_q        <= done_d;
      read_bits_q   <= read_bits_d;
      index_valid_q <= index_valid_d;
      if (cfg_we_i) begin
        grid_size_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        row_vld_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    up_q  <= up_d;
    mid_q <= mid_d;
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    idx_vld_d     = idx_vld_q;
    up_d          = up_q;
    mid_d         = mid_q;
    ram_we        = 1'b0;
    ram_waddr     = row_index_i[AW-1:0];
    ram_wdata     = row_bits_i & col_mask(n_act);
    ram_raddr     = row_index_i[AW-1:0];
    done_d        = 1'b0;
    read_bits_d   = '0;
    index_valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_vld_d = idx_ok;
          cnt_d     = '0;
          unique case (cmd_e'(command_i))
            CMD_WRITE: begin
              ram_we        = idx_ok;
              done_d        = 1'b1;
              index_valid_d = idx_ok;
            end
            CMD_READ: begin
              state_d = ST_READ;
            end
            CMD_ADVANCE: begin
              state_d = ST_ADV;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        done_d        = 1'b1;
        index_valid_d = idx_vld_q;
        read_bits_d   = rdata_m & col_mask(n_act) & {COLS{idx_vld_q}};
        state_d       = ST_IDLE;
      end
      ST_ADV: begin
        ram_raddr = cnt_q[AW-1:0];
        up_d      = mid_q;
        mid_d     = rdata_m;
        ram_waddr = wrow[AW-1:0];
        if ((wrow == '0) || (wrow == (n_act - SIZE_W'(1)))) begin
          ram_wdata = '0;
        end else begin
          ram_wdata = life_rule(up_q, mid_q, rdata_m) & inner_mask(n_act);
        end
        ram_we = (cnt_q >= SIZE_W'(2));
        if (cnt_q == (n_act + SIZE_W'(1))) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + SIZE_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign done_o        = done_q;
  assign read_bits_o   = read_bits_q;
  assign index_valid_o = index_valid_q;

  `LGS_ASSERT_NOW(a_quiet_idle, !done_o, (read_bits_o == '0) && !index_valid_o, "result fields set without strobe")
  `LGS_ASSERT_NOW(a_bits_need_index, done_o && !index_valid_o, read_bits_o == '0, "read bits on invalid index")
  `LGS_ASSERT_NEXT(a_read_done, state_q == ST_READ, done_o && !busy, "read result not delivered")
  `LGS_ASSERT_NOW(a_sweep_bound, state_q == ST_ADV, cnt_q <= (n_act + SIZE_W'(1)), "advance sweep overran")
  `LGS_ASSERT_NOW(a_no_write_on_read, state_q == ST_READ, !ram_we, "grid written during read")

endmodule
